// ----- rtl/core/mea_pkg.sv -----
// Shared types, constants and helper functions of the elite archive.
// Used by every module under rtl/core; depends on nothing.
package mea_pkg;

	// Geometry of the archive
	localparam int NUM_DIMS    = 4;
	localparam int NUM_BINS    = 4;
	localparam int COORD_W     = 16;
	localparam int LIMIT_W     = 16;
	localparam int LIMITS_W    = NUM_BINS * LIMIT_W;
	localparam int NUM_CELLS   = 256;
	localparam int CELL_W      = $clog2(NUM_CELLS);
	localparam int SCORE_W     = 32;
	localparam int HANDLE_W    = 16;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int CNT_W       = 3;
	localparam int COUNTS_W    = NUM_DIMS * CNT_W;
	localparam int DIMS_W      = 3;

	// Configuration port
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_IDX_W-1:0] REG_LIMITS0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS3    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNTS = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS       = 3'd5;

	localparam logic [COUNTS_W-1:0] BIN_COUNTS_RESET = 12'd2340;
	localparam logic [DIMS_W-1:0]   DIMS_RESET       = 3'd4;

	// Request commands
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic                        cmd;
		logic signed [COORD_W-1:0]   coord0;
		logic signed [COORD_W-1:0]   coord1;
		logic signed [COORD_W-1:0]   coord2;
		logic signed [COORD_W-1:0]   coord3;
		logic signed [SCORE_W-1:0]   score;
		logic        [HANDLE_W-1:0]  handle;
		logic        [CELL_W-1:0]    cell_addr;
	} req_t;

	typedef struct packed {
		logic        [CELL_W-1:0]    cell_index;
		logic                        replaced;
		logic                        out_of_range;
		logic                        was_visited;
		logic signed [SCORE_W-1:0]   cell_score;
		logic        [HANDLE_W-1:0]  cell_handle;
	} rsp_t;

	// Classified request, as it waits in the queue
	typedef struct packed {
		logic                        cmd;
		logic                        out_of_range;
		logic        [CELL_W-1:0]    cell_id;
		logic signed [SCORE_W-1:0]   score;
		logic        [HANDLE_W-1:0]  handle;
	} work_t;

	// Bins in use for one dimension: zero counts as one, cap at NUM_BINS
	function automatic logic [CNT_W-1:0] clamp_bins(input logic [CNT_W-1:0] raw);
		logic [CNT_W-1:0] n;
		n = raw;
		if (n == '0)
			n = CNT_W'(1);
		else if (n > CNT_W'(NUM_BINS))
			n = CNT_W'(NUM_BINS);
		return n;
	endfunction

	// Dimensions in use: zero counts as one, cap at NUM_DIMS
	function automatic logic [DIMS_W-1:0] clamp_dims(input logic [DIMS_W-1:0] raw);
		logic [DIMS_W-1:0] n;
		n = raw;
		if (n == '0)
			n = DIMS_W'(1);
		else if (n > DIMS_W'(NUM_DIMS))
			n = DIMS_W'(NUM_DIMS);
		return n;
	endfunction

endpackage

// ----- rtl/core/mea_front.sv -----
// Front end of the elite archive: configuration registers, request intake,
// coordinate binning and cell index. Depends on mea_pkg.
module mea_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mea_pkg::req_t                   req,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mea_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            q_full,
	output logic                            q_push,
	output mea_pkg::work_t                  q_data
);
	import mea_pkg::*;

	typedef struct packed {
		logic             found;
		logic [BIN_W-1:0] bin;
	} bin_res_t;

	logic [LIMITS_W-1:0] limits_q [NUM_DIMS];
	logic [COUNTS_W-1:0] bin_counts_q;
	logic [DIMS_W-1:0]   dims_q;

	logic                    accept;
	logic [DIMS_W-1:0]       nd;
	logic [CNT_W-1:0]        nbins [NUM_DIMS];
	logic signed [COORD_W-1:0] coords [NUM_DIMS];
	bin_res_t                res [NUM_DIMS];
	logic                    oor_d;

	logic                    valid_s1;
	logic                    cmd_s1;
	logic                    oor_s1;
	logic [BIN_W-1:0]        bins_s1 [NUM_DIMS];
	logic signed [SCORE_W-1:0] score_s1;
	logic [HANDLE_W-1:0]     handle_s1;
	logic [CELL_W-1:0]       addr_s1;

	logic [CELL_W-1:0]       idx;
	logic [CELL_W+CNT_W-1:0] prod;

	// First bin whose threshold the coordinate does not exceed
	function automatic bin_res_t bin_lookup(
		input logic signed [COORD_W-1:0] c,
		input logic [LIMITS_W-1:0]       lims,
		input logic [CNT_W-1:0]          n
	);
		bin_res_t                  r;
		logic signed [LIMIT_W-1:0] lim_a;
		logic signed [LIMIT_W-1:0] lim_b;
		logic signed [COORD_W:0]   c1;
		logic signed [COORD_W+1:0] c2;
		logic signed [LIMIT_W:0]   top;
		logic signed [LIMIT_W+1:0] mid;
		logic                      le;
		r  = '0;
		c1 = {c[COORD_W-1], c};
		c2 = {c[COORD_W-1], c, 1'b0};
		for (int j = NUM_BINS - 1; j >= 0; j--) begin
			lim_a = lims[j*LIMIT_W +: LIMIT_W];
			lim_b = lims[((j + 1) % NUM_BINS)*LIMIT_W +: LIMIT_W];
			top   = {lim_a[LIMIT_W-1], lim_a} + (LIMIT_W+1)'(1);
			mid   = {{2{lim_a[LIMIT_W-1]}}, lim_a} + {{2{lim_b[LIMIT_W-1]}}, lim_b};
			if (CNT_W'(j + 1) == n)
				le = (c1 <= top);
			else
				le = (c2 <= mid);
			if (CNT_W'(j) < n && le) begin
				r.found = 1'b1;
				r.bin   = BIN_W'(j);
			end
		end
		return r;
	endfunction

	// Configuration writes, taken whenever offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++)
				limits_q[d] <= '0;
			bin_counts_q <= BIN_COUNTS_RESET;
			dims_q       <= DIMS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				[REG_LIMITS0:REG_LIMITS3]: limits_q[cfg_index[1:0]] <= cfg_data;
				REG_BIN_COUNTS: bin_counts_q <= cfg_data[COUNTS_W-1:0];
				REG_DIMS:       dims_q       <= cfg_data[DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// Bin every coordinate in parallel, one lane per dimension
	assign coords[0] = req.coord0;
	assign coords[1] = req.coord1;
	assign coords[2] = req.coord2;
	assign coords[3] = req.coord3;
	assign nd        = clamp_dims(dims_q);

	always_comb begin
		oor_d = 1'b0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			nbins[d] = clamp_bins(bin_counts_q[d*CNT_W +: CNT_W]);
			res[d]   = bin_lookup(coords[d], limits_q[d], nbins[d]);
			if (DIMS_W'(d) < nd && !res[d].found)
				oor_d = 1'b1;
		end
	end

	// Hold the request while the queue is full
	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept || (valid_s1 && q_full);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= req.cmd;
			oor_s1    <= oor_d;
			score_s1  <= req.score;
			handle_s1 <= req.handle;
			addr_s1   <= req.cell_addr;
			for (int d = 0; d < NUM_DIMS; d++)
				bins_s1[d] <= res[d].bin;
		end
	end

	// Fold the bins into a mixed-radix cell index, dimension 0 most significant
	always_comb begin
		idx  = '0;
		prod = '0;
		for (int d = 0; d < NUM_DIMS; d++) begin
			if (DIMS_W'(d) < nd) begin
				prod = idx * nbins[d] + (CELL_W+CNT_W)'(bins_s1[d]);
				idx  = prod[CELL_W-1:0];
			end
		end
	end

	always_comb begin
		q_data.cmd    = cmd_s1;
		q_data.score  = score_s1;
		q_data.handle = handle_s1;
		if (cmd_s1 == CMD_READ) begin
			q_data.out_of_range = 1'b0;
			q_data.cell_id      = addr_s1;
		end else begin
			q_data.out_of_range = oor_s1;
			q_data.cell_id      = oor_s1 ? '0 : idx;
		end
	end

endmodule

// ----- rtl/core/mea_queue.sv -----
// Short request queue between front and back end of the elite archive.
// Depends on mea_pkg.
module mea_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mea_pkg::work_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output mea_pkg::work_t  head
);
	import mea_pkg::*;

	work_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

	// Advance pointers and track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue occupancy beyond depth");

endmodule

// ----- rtl/core/mea_back.sv -----
// Back end of the elite archive: cell memory, visited marks and the
// read-modify-write of one cell per request. Depends on mea_pkg.
module mea_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_not_empty,
	input  mea_pkg::work_t  q_head,
	output logic            q_pop,
	output logic            done,
	output mea_pkg::rsp_t   rsp
);
	import mea_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_UPDATE = 2'b10
	} back_state_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] score;
		logic [HANDLE_W-1:0]       handle;
	} elite_t;

	elite_t                 elite_mem [NUM_CELLS];
	elite_t                 rd_q;
	logic [NUM_CELLS-1:0]   visited_q;
	back_state_t            state_q;
	work_t                  work_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	logic                      was;
	logic signed [SCORE_W-1:0] old_score;
	logic [HANDLE_W-1:0]       old_handle;
	logic                      repl;
	rsp_t                      rsp_d;

	// Take the next request only between updates
	assign q_pop = (state_q == ST_IDLE) && q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (q_pop) state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// Latch the request and read its cell
	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_head;
			rd_q   <= elite_mem[q_head.cell_id];
		end
	end

	// Decide on the stored elite; an unvisited cell reads as empty
	always_comb begin
		was        = visited_q[work_q.cell_id];
		old_score  = was ? rd_q.score : '0;
		old_handle = was ? rd_q.handle : '0;
		repl       = (work_q.cmd == CMD_INSERT) && (!was || (work_q.score > old_score));

		rsp_d.cell_index   = work_q.cell_id;
		rsp_d.replaced     = repl;
		rsp_d.out_of_range = work_q.out_of_range;
		rsp_d.was_visited  = was;
		rsp_d.cell_score   = repl ? work_q.score : old_score;
		rsp_d.cell_handle  = repl ? work_q.handle : old_handle;
	end

	// Write back the new elite
	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE && repl)
			elite_mem[work_q.cell_id] <= '{score: work_q.score, handle: work_q.handle};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			visited_q <= '0;
		else if (state_q == ST_UPDATE && repl)
			visited_q[work_q.cell_id] <= 1'b1;
	end

	// Register the result for one strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= (state_q == ST_UPDATE);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE)
			rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without an update cycle");

	a_result_cell: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rsp_q.cell_index == work_q.cell_id))
		else $error("result names a cell other than the request's");

	a_read_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && work_q.cmd == CMD_READ) |-> (!rsp_q.replaced && !rsp_q.out_of_range))
		else $error("read request reports a store or range flag");

	a_store_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && repl) |=> visited_q[$past(work_q.cell_id)])
		else $error("stored elite left its cell unvisited");

endmodule

// ----- rtl/core/map_elites_archive_insert.sv -----
// Elite archive over a grid of behavior bins: insert and read requests.
// A taken request is registered in the front end, queued, then latched by the back end.
// The back end takes a new request only once the cell read-modify-write is done.
// A two-entry queue lets intake run ahead; busy rises only when it is full.
// Reset clears all cells to unvisited at once; results cannot be stalled.
module map_elites_archive_insert (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  mea_pkg::req_t                   req,
	output logic                            done,
	output mea_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mea_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mea_pkg::*;

	logic  q_full;
	logic  q_push;
	work_t q_data;
	logic  q_pop;
	logic  q_not_empty;
	work_t q_head;

	// Classify requests into cell operations
	mea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_data)
	);

	// Decouple intake from cell updates
	mea_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// Carry out cell reads and updates
	mea_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.done        (done),
		.rsp         (rsp)
	);

endmodule

// ----- sim/archive_checker.sv -----
// Scoreboard for the elite archive: mirrors the cells and the registers,
// predicts one result per accepted request and compares it field by field.
// Depends on mea_pkg.
module archive_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  mea_pkg::req_t                   req,
	input  logic                            done,
	input  mea_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [mea_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mea_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int unsigned                     fault_count,
	output int unsigned                     outstanding,
	output logic [mea_pkg::NUM_CELLS-1:0]   cell_taken
);
	import mea_pkg::*;

	localparam int REPORT_LIMIT = 10;

	logic [LIMITS_W-1:0]        limit_cfg [NUM_DIMS];
	logic [COUNTS_W-1:0]        counts_cfg;
	logic [DIMS_W-1:0]          dims_cfg;
	logic [NUM_CELLS-1:0]       visited;
	logic signed [SCORE_W-1:0]  elite_score [NUM_CELLS];
	logic [HANDLE_W-1:0]        elite_handle [NUM_CELLS];
	rsp_t                       expected_results [$];
	int unsigned                faults;

	// Limit j of dimension d, sign-extended
	function automatic longint limit_at(input int d, input int j);
		return longint'($signed(limit_cfg[d][LIMIT_W*j +: LIMIT_W]));
	endfunction

	// Bin every coordinate in use and fold the bins into a mixed-radix cell index
	function automatic logic [CELL_W-1:0] locate_cell(input req_t r, output logic beyond);
		logic signed [COORD_W-1:0] crd [NUM_DIMS];
		longint c;
		int nd, n, bin, idx;
		logic hit;
		crd = '{r.coord0, r.coord1, r.coord2, r.coord3};
		beyond = 1'b0;
		idx = 0;
		nd = int'(dims_cfg);
		if (nd == 0)
			nd = 1;
		else if (nd > NUM_DIMS)
			nd = NUM_DIMS;
		for (int d = 0; d < nd; d++) begin
			n = int'(counts_cfg[CNT_W*d +: CNT_W]);
			if (n == 0)
				n = 1;
			else if (n > NUM_BINS)
				n = NUM_BINS;
			c = longint'(crd[d]);
			hit = 1'b0;
			bin = 0;
			for (int j = 0; j < n; j++) begin
				// last bin reaches one LSB past its limit, inner bins stop at the midpoint
				if (j == n - 1)
					hit = (c <= limit_at(d, j) + 1);
				else
					hit = (2 * c <= limit_at(d, j) + limit_at(d, j + 1));
				if (hit) begin
					bin = j;
					break;
				end
			end
			if (!hit) begin
				beyond = 1'b1;
				return '0;
			end
			idx = idx * n + bin;
		end
		return CELL_W'(idx % NUM_CELLS);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		logic beyond;
		logic [CELL_W-1:0] slot;
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIMS; d++)
				limit_cfg[d] = '0;
			counts_cfg = BIN_COUNTS_RESET;
			dims_cfg = DIMS_RESET;
			visited = '0;
			for (int i = 0; i < NUM_CELLS; i++)
				elite_score[i] = '0;
			expected_results.delete();
			faults = 0;
		end else begin
			// Match a finished result against the oldest prediction
			if (done) begin
				if (expected_results.size() == 0) begin
					faults++;
					if (faults <= REPORT_LIMIT)
						$display("unexpected result: cell %0d score %h handle %h",
							rsp.cell_index, rsp.cell_score, rsp.cell_handle);
				end else begin
					want = expected_results.pop_front();
					if (rsp.cell_index !== want.cell_index || rsp.replaced !== want.replaced ||
						rsp.out_of_range !== want.out_of_range ||
						rsp.was_visited !== want.was_visited ||
						rsp.cell_score !== want.cell_score ||
						rsp.cell_handle !== want.cell_handle) begin
						faults++;
						if (faults <= REPORT_LIMIT) begin
							$display("mismatch expected: cell %0d repl %b oor %b vis %b score %h handle %h",
								want.cell_index, want.replaced, want.out_of_range,
								want.was_visited, want.cell_score, want.cell_handle);
							$display("         actual:   cell %0d repl %b oor %b vis %b score %h handle %h",
								rsp.cell_index, rsp.replaced, rsp.out_of_range,
								rsp.was_visited, rsp.cell_score, rsp.cell_handle);
						end
					end
				end
			end

			// Track register writes; unmapped indexes are dropped
			if (cfg_valid && cfg_ready) begin
				if (cfg_index >= REG_LIMITS0 && cfg_index <= REG_LIMITS3)
					limit_cfg[cfg_index - REG_LIMITS0] = cfg_data;
				else if (cfg_index == REG_BIN_COUNTS)
					counts_cfg = cfg_data[COUNTS_W-1:0];
				else if (cfg_index == REG_DIMS)
					dims_cfg = cfg_data[DIMS_W-1:0];
			end

			// Predict the result of an accepted request and update the cells
			if (start && !busy) begin
				want = '0;
				if (req.cmd == CMD_INSERT) begin
					slot = locate_cell(req, beyond);
					want.out_of_range = beyond;
					want.was_visited = visited[slot];
					if (!visited[slot] || $signed(req.score) > $signed(elite_score[slot])) begin
						elite_score[slot] = req.score;
						elite_handle[slot] = req.handle;
						visited[slot] = 1'b1;
						want.replaced = 1'b1;
					end
				end else begin
					slot = req.cell_addr;
					want.was_visited = visited[slot];
				end
				want.cell_index = slot;
				want.cell_score = elite_score[slot];
				want.cell_handle = visited[slot] ? elite_handle[slot] : '0;
				expected_results.insert(expected_results.size(), want);
			end
		end
		fault_count <= faults;
		outstanding <= expected_results.size();
		cell_taken <= visited;
	end

endmodule

// ----- sim/testbench.sv -----
// Top of the elite archive testbench: clock, reset, request and register
// stimulus, watchdog and verdict. Depends on mea_pkg, archive_checker and
// map_elites_archive_insert.
module testbench;
	import mea_pkg::*;

	localparam int NUM_PHASES     = 8;
	localparam int RAND_PER_PHASE = 217;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Limits -1.0, 0.0, 1.0, 2.0 in Q6.10, limit 0 in the low bits
	localparam logic [LIMITS_W-1:0] STEP_LIMITS = 64'h0800_0400_0000_FC00;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           fault_count;
	int unsigned           outstanding;
	logic [NUM_CELLS-1:0]  cell_taken;
	int unsigned           idle_cycles = 0;

	// Register values of the current phase
	logic [LIMITS_W-1:0]   lim_set [NUM_DIMS];
	logic [COUNTS_W-1:0]   bins_set;
	logic [DIMS_W-1:0]     dims_set;

	map_elites_archive_insert dut (.*);

	archive_checker elite_check (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Four random limits in increasing order, often packed close together
	function automatic logic [LIMITS_W-1:0] sorted_limits();
		logic signed [LIMIT_W-1:0] v [NUM_BINS];
		logic signed [LIMIT_W-1:0] t;
		logic [LIMITS_W-1:0] lim_word;
		for (int i = 0; i < NUM_BINS; i++)
			v[i] = $urandom_range(0, 1) ? LIMIT_W'($urandom) : LIMIT_W'($urandom_range(0, 8191) - 4096);
		for (int i = 0; i < NUM_BINS - 1; i++)
			for (int j = 0; j < NUM_BINS - 1 - i; j++)
				if (v[j] > v[j + 1]) begin
					t = v[j];
					v[j] = v[j + 1];
					v[j + 1] = t;
				end
		for (int i = 0; i < NUM_BINS; i++)
			lim_word[LIMIT_W*i +: LIMIT_W] = v[i];
		return lim_word;
	endfunction

	// Coordinate aimed at a bin edge of dimension d, or anywhere
	function automatic logic [COORD_W-1:0] pick_coord(input int d);
		int j, lo, hi, mid, off;
		j = $urandom_range(0, NUM_BINS - 2);
		lo = int'($signed(lim_set[d][LIMIT_W*j +: LIMIT_W]));
		hi = int'($signed(lim_set[d][LIMIT_W*(j + 1) +: LIMIT_W]));
		mid = (lo + hi) >>> 1;
		off = $urandom_range(0, 6);
		case ($urandom_range(0, 3))
			0: return COORD_W'($urandom);
			1: return COORD_W'(lo + off - 3);
			2: return COORD_W'(hi + off - 3);
			default: return COORD_W'(mid + off - 3);
		endcase
	endfunction

	// Mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 0;
			6, 7, 8: return $urandom_range(1, 3);
			default: return $urandom_range(8, 40);
		endcase
	endfunction

	function automatic req_t insert_req(input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] c1,
		input logic [COORD_W-1:0] c2, input logic [COORD_W-1:0] c3,
		input logic [SCORE_W-1:0] sc, input logic [HANDLE_W-1:0] h);
		req_t r;
		r.cmd = CMD_INSERT;
		r.coord0 = c0;
		r.coord1 = c1;
		r.coord2 = c2;
		r.coord3 = c3;
		r.score = sc;
		r.handle = h;
		r.cell_addr = CELL_W'($urandom);
		return r;
	endfunction

	function automatic req_t read_req(input logic [CELL_W-1:0] addr);
		req_t r;
		r.cmd = CMD_READ;
		r.coord0 = COORD_W'($urandom);
		r.coord1 = COORD_W'($urandom);
		r.coord2 = COORD_W'($urandom);
		r.coord3 = COORD_W'($urandom);
		r.score = $urandom;
		r.handle = HANDLE_W'($urandom);
		r.cell_addr = addr;
		return r;
	endfunction

	// Hold a register write until it is taken; the caller drops valid
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Hold a request until the archive takes it
	task automatic send(input req_t r, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending until every predicted result is back, then let the pipe settle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [SCORE_W-1:0] sc;
		logic [CFG_DATA_W-1:0] junk;
		req_t r;
		int a;
		logic quiet;
		start <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			// Choose this phase's registers
			case (phase)
				0: begin
					for (int d = 0; d < NUM_DIMS; d++)
						lim_set[d] = STEP_LIMITS;
					bins_set = BIN_COUNTS_RESET;
					dims_set = DIMS_RESET;
				end
				1: begin
					// zero bin counts act as one bin, too many dimensions cap at four
					for (int d = 0; d < NUM_DIMS; d++)
						lim_set[d] = sorted_limits();
					bins_set = '0;
					dims_set = 3'd7;
				end
				2: begin
					// oversized bin counts cap, zero dimensions act as one
					for (int d = 0; d < NUM_DIMS; d++)
						lim_set[d] = sorted_limits();
					bins_set = '1;
					dims_set = '0;
				end
				3: begin
					lim_set[0] = 64'h7FFF_7FFF_7FFF_7FFF;
					lim_set[1] = 64'h8000_8000_8000_8000;
					lim_set[2] = 64'h7FFF_0000_FFFF_8000;
					lim_set[3] = sorted_limits();
					bins_set = BIN_COUNTS_RESET;
					dims_set = DIMS_RESET;
				end
				default: begin
					for (int d = 0; d < NUM_DIMS; d++)
						lim_set[d] = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : sorted_limits();
					if ($urandom_range(0, 3) == 0) begin
						bins_set = COUNTS_W'($urandom);
					end else begin
						for (int d = 0; d < NUM_DIMS; d++)
							bins_set[CNT_W*d +: CNT_W] = CNT_W'($urandom_range(1, NUM_BINS));
					end
					dims_set = ($urandom_range(0, 3) == 0) ? DIMS_W'($urandom_range(0, 7))
						: DIMS_W'($urandom_range(2, NUM_DIMS));
				end
			endcase

			// Program the archive while it is idle; upper data bits carry noise
			for (int d = 0; d < NUM_DIMS; d++)
				write_reg(CFG_IDX_W'(REG_LIMITS0 + d), lim_set[d]);
			junk = {$urandom, $urandom};
			junk[COUNTS_W-1:0] = bins_set;
			write_reg(REG_BIN_COUNTS, junk);
			junk = {$urandom, $urandom};
			junk[DIMS_W-1:0] = dims_set;
			write_reg(REG_DIMS, junk);
			if (phase == 2) begin
				write_reg(REG_SPARE_LO, {$urandom, $urandom});
				write_reg(REG_SPARE_HI, {$urandom, $urandom});
			end
			cfg_valid <= 1'b0;

			if (phase == 0) begin
				// Lowest coordinates and score into a fresh cell, then a tie that must not replace
				send(insert_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 16'h0000), 0);
				send(insert_req(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000, 16'hFFFF), 0);
				// One LSB past the last limit still lands in the last bin: cell 255
				send(insert_req(16'd2049, 16'd2049, 16'd2049, 16'd2049, 32'h7FFF_FFFF, 16'hFFFF),
					pick_gap());
				// Beyond every bin: flagged and folded onto cell 0
				send(insert_req(16'd2049, 16'd2049, 16'd2049, 16'd2050, 32'h0000_0000, 16'h5A5A), 0);
				send(insert_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 16'hA5A5),
					pick_gap());
				// Exact midpoints on either side: cells 22 and 176
				send(insert_req(-16'sd512, -16'sd511, 16'd512, 16'd513, 32'd100, 16'h0001), 0);
				send(insert_req(16'd1536, 16'd1537, -16'sd512, -16'sd513, 32'd200, 16'h0002), 0);
				// Lower score keeps the elite, higher score takes over
				send(insert_req(-16'sd512, -16'sd511, 16'd512, 16'd513, 32'd99, 16'h0003), pick_gap());
				send(insert_req(-16'sd512, -16'sd511, 16'd512, 16'd513, 32'd101, 16'h0004), 0);
				send(insert_req(16'd1536, 16'd1537, -16'sd512, -16'sd513, 32'hFFFF_FFFF, 16'h0005), 0);
				send(read_req(8'd0), 0);
				send(read_req(8'd255), pick_gap());
				send(read_req(8'd22), 0);
				send(read_req(8'd176), 0);
				// Zero and minus one LSB share the second bin: cell 85
				send(insert_req(16'd0, 16'd0, 16'd0, 16'd0, -32'sd5, 16'h1234), 0);
				send(insert_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, -32'sd4, 16'hEDCB), pick_gap());
			end

			quiet = (phase % 3 == 1);
			for (int k = 0; k < RAND_PER_PHASE; k++) begin
				if ($urandom_range(0, 4) == 0 && cell_taken != '0) begin
					// read back a cell that already holds an elite
					a = $urandom_range(0, NUM_CELLS - 1);
					while (!cell_taken[a])
						a = (a + 1) % NUM_CELLS;
					r = read_req(CELL_W'(a));
				end else begin
					case ($urandom_range(0, 9))
						0: sc = 32'h8000_0000;
						1: sc = 32'h7FFF_FFFF;
						2, 3, 4: sc = $urandom_range(0, 16) - 8;
						default: sc = $urandom;
					endcase
					r = insert_req(pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3),
						sc, HANDLE_W'($urandom));
				end
				send(r, quiet ? 0 : pick_gap());
				if ($urandom_range(0, 149) == 0)
					drain();
			end
			drain();
		end

		if (fault_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
